// File: hdl/palette_frame_scaler_rgb5551_top_defines.svh
// Assertion macros for the palette frame scaler checker.
// Depends on nothing; the asserting module supplies i_clk and i_rst_n.
`ifndef PALETTE_FRAME_SCALER_RGB5551_TOP_DEFINES_SVH
`define PALETTE_FRAME_SCALER_RGB5551_TOP_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define PFS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while in reset.
`define PFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Holds in the cycle after reset is sampled low.
`define PFS_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pfs_pkg.sv
// Shared constants and types for the palette frame scaler.
// No dependencies; used by the top level and its checker.
package pfs_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int SRC_COLS_W = 11;
    localparam int SRC_ROWS_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS = 1'd1;

    localparam logic [SRC_COLS_W-1:0] SOURCE_COLS_RST = 11'd320;
    localparam logic [SRC_ROWS_W-1:0] SOURCE_ROWS_RST = 12'd240;

    // input item kinds
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    // payload widths
    localparam int CHAN_W       = 8;
    localparam int INDEX_W      = 8;
    localparam int PIX_W        = 16;
    localparam int COLOR_W      = 15;
    localparam int ROW_PORT_W   = 8;
    localparam int GROUP_PORT_W = 5;
    localparam int GROUP_PIX    = 8;
    localparam int FRAC_BITS    = 16;

    typedef logic [COLOR_W-1:0] t_color;

endpackage

// File: hdl/palette_frame_scaler_rgb5551_top.sv
// Palette expander and nearest-neighbor frame scaler, RGBA5551 output.
// Depends on pfs_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one transaction is either a
//   palette entry write (i_kind = palette) or one 8-bit indexed source pixel
//   in raster order. Output channel (o_out_valid / i_out_ready): one
//   transaction is a group of eight RGBA5551 pixels of an OUT_DIM-wide row,
//   tagged with row number, group number and a last-of-run flag.
//   Config port: i_cfg_we writes source_cols / source_rows; write only idle.
// Flow:
//   Palette writes and pixels that do not close a row are taken without
//   holding off input. A row-closing pixel holds off input through S_MUL
//   and S_DEC for row selection. If it selects an output row, S_DIV forms
//   the column step (multiply by a constant reciprocal of OUT_DIM), then
//   per group S_FETCH issues 8 line-store reads feeding the palette read,
//   each result passing the line-store and palette read registers, and
//   S_OUT holds for the output handshake. A guard row reuses the step.
//   Each memory has one read port. Input is not taken while a row is being emitted.
// Reset: synchronous, clears counters and config to 320 x 240; the memories
//   hold garbage until written. A stalled receiver freezes emission; the
//   held group stays on the output ports unchanged.
module palette_frame_scaler_rgb5551_top #(
    parameter int OUT_DIM         = 256,
    parameter int MAX_SOURCE_COLS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [pfs_pkg::INDEX_W-1:0]         i_pal_index,
    input  logic [pfs_pkg::CHAN_W-1:0]          i_red,
    input  logic [pfs_pkg::CHAN_W-1:0]          i_green,
    input  logic [pfs_pkg::CHAN_W-1:0]          i_blue,
    input  logic [pfs_pkg::INDEX_W-1:0]         i_pixel_index,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix0,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix1,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix2,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix3,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix4,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix5,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix6,
    output logic [pfs_pkg::PIX_W-1:0]           o_pix7,
    output logic [pfs_pkg::ROW_PORT_W-1:0]      o_out_row,
    output logic [pfs_pkg::GROUP_PORT_W-1:0]    o_group,
    output logic                                o_last_of_run
);

    // widths derived from the parameters
    localparam int CW     = $clog2(MAX_SOURCE_COLS + 1);   // effective cols
    localparam int LAW    = $clog2(MAX_SOURCE_COLS);       // line store address
    localparam int EW     = (CW > pfs_pkg::SRC_COLS_W) ? CW : pfs_pkg::SRC_COLS_W;
    localparam int NW     = CW + pfs_pkg::FRAC_BITS;       // CW.16 numerator / step
    localparam int NOW    = $clog2(OUT_DIM + 1);           // output row counter
    localparam int PW     = NOW + 13;                      // row-select products
    localparam int GROUPS = OUT_DIM / pfs_pkg::GROUP_PIX;
    localparam int GW     = $clog2(GROUPS);
    localparam int RW     = pfs_pkg::SRC_ROWS_W;

    // step = cols*2^16/OUT_DIM as cols * ceil(2^(NW+LW)/OUT_DIM) >> (CW+LW);
    // exact for every numerator below 2^NW
    localparam int LW = $clog2(OUT_DIM);
    localparam int MW = NW + 1;                            // reciprocal width
    localparam int QW = CW + MW;                           // product width
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << (NW + LW)) + 64'(OUT_DIM) - 64'd1) / 64'(OUT_DIM));

    localparam logic [3:0] FETCH_ISSUE = 4'd8;   // reads issued per group
    localparam logic [3:0] PIPE_LAT    = 4'd2;   // line read + palette read
    localparam logic [3:0] FETCH_LAST  = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DEC,
        S_DIV,
        S_FETCH,
        S_OUT
    } t_state;

    t_state                         r_state;

    // configuration
    logic [pfs_pkg::SRC_COLS_W-1:0] r_source_cols;
    logic [RW-1:0]                  r_source_rows;

    // frame counters
    logic [LAW-1:0]                 r_col_count;
    logic [RW-1:0]                  r_row_count;
    logic [NOW-1:0]                 r_nor;        // next output row

    // row selection
    logic [PW-1:0]                  r_prod;
    logic [PW-1:0]                  r_lo;

    // column step, kept for the guard row
    logic [NW-1:0]                  r_quo;

    // emission
    logic [NW-1:0]                  r_frac;
    logic [NOW-1:0]                 r_orow;
    logic                           r_two;        // guard row still pending
    logic [GW-1:0]                  r_group;
    logic [3:0]                     r_cnt;
    pfs_pkg::t_color                r_pix [pfs_pkg::GROUP_PIX];
    logic                           r_out_valid;

    // memories
    logic [pfs_pkg::INDEX_W-1:0]    r_line_mem [MAX_SOURCE_COLS];
    logic [pfs_pkg::INDEX_W-1:0]    r_line_q;
    pfs_pkg::t_color                r_pal_mem [256];
    pfs_pkg::t_color                r_pal_q;

    logic                           in_acc;
    logic                           pix_we;
    logic                           pal_we;
    logic [EW-1:0]                  cols_ext;
    logic [CW-1:0]                  eff_cols;
    logic [RW-1:0]                  eff_rows;
    logic                           col_more;
    logic [RW:0]                    rc1;
    logic                           short_src;
    logic                           short_emit;
    logic                           guard;
    logic                           tall_emit;
    logic                           emit;
    logic                           frame_end;
    logic [PW-1:0]                  lo_hi;
    logic [QW-1:0]                  step_prod;
    logic [NW-1:0]                  step;
    logic [LAW-1:0]                 line_raddr;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign pix_we     = in_acc && (i_kind == pfs_pkg::KIND_PIXEL);
    assign pal_we     = in_acc && (i_kind == pfs_pkg::KIND_PALETTE);

    // clamp width to 1..MAX_SOURCE_COLS, height to 1..
    assign cols_ext = EW'(r_source_cols);
    always_comb begin
        if (r_source_cols == '0) begin
            eff_cols = CW'(1);
        end else if (cols_ext > EW'(MAX_SOURCE_COLS)) begin
            eff_cols = CW'(MAX_SOURCE_COLS);
        end else begin
            eff_cols = CW'(cols_ext);
        end
    end
    assign eff_rows = (r_source_rows == '0) ? RW'(1) : r_source_rows;

    assign col_more = (CW'(r_col_count) + CW'(1)) < eff_cols;

    // row decision
    assign rc1        = (RW+1)'(r_row_count) + (RW+1)'(1);
    assign short_src  = eff_rows <= RW'(OUT_DIM);
    assign short_emit = r_row_count < RW'(OUT_DIM);
    assign guard      = (eff_rows < RW'(OUT_DIM)) && (rc1 >= (RW+1)'(eff_rows))
                        && (rc1 < (RW+1)'(OUT_DIM));
    // source row floor(nor*rows/OUT_DIM) == row_count, as a range check
    assign lo_hi      = r_lo + PW'(OUT_DIM);
    assign tall_emit  = (r_nor < NOW'(OUT_DIM)) && (r_prod >= r_lo) && (r_prod < lo_hi);
    assign emit       = short_src ? short_emit : tall_emit;
    assign frame_end  = rc1 >= (RW+1)'(eff_rows);

    // column step by constant reciprocal
    assign step_prod = QW'(eff_cols) * QW'(RECIP);
    assign step      = NW'(step_prod[QW-1:CW+LW]);

    assign line_raddr = r_frac[pfs_pkg::FRAC_BITS +: LAW];

    // line store: written by incoming pixels, read by the column walk
    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_line_mem[r_col_count] <= i_pixel_index;
        end
        r_line_q <= r_line_mem[line_raddr];
    end

    // palette: packed BGR555, read with the line store output
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal_mem[i_pal_index] <= {i_blue[7:3], i_green[7:3], i_red[7:3]};
        end
        r_pal_q <= r_pal_mem[r_line_q];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_source_cols <= pfs_pkg::SOURCE_COLS_RST;
            r_source_rows <= pfs_pkg::SOURCE_ROWS_RST;
            r_col_count   <= '0;
            r_row_count   <= '0;
            r_nor         <= '0;
            r_two         <= 1'b0;
            r_group       <= '0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfs_pkg::REG_SOURCE_COLS: begin
                        r_source_cols <= i_cfg_data[pfs_pkg::SRC_COLS_W-1:0];
                    end
                    pfs_pkg::REG_SOURCE_ROWS: begin
                        r_source_rows <= i_cfg_data[RW-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (pix_we) begin
                        if (col_more) begin
                            r_col_count <= r_col_count + LAW'(1);
                        end else begin
                            r_col_count <= '0;
                            r_state     <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    r_prod  <= PW'(r_nor) * PW'(eff_rows);
                    r_lo    <= PW'(r_row_count) * PW'(OUT_DIM);
                    r_state <= S_DEC;
                end

                S_DEC: begin
                    if (short_src) begin
                        if (short_emit) begin
                            r_orow <= NOW'(r_row_count);
                            r_nor  <= NOW'(rc1);
                            r_two  <= guard;
                        end
                    end else if (tall_emit) begin
                        r_orow <= r_nor;
                        r_nor  <= r_nor + NOW'(1);
                        r_two  <= 1'b0;
                    end
                    // end of frame overrides the row advance above
                    if (frame_end) begin
                        r_row_count <= '0;
                        r_nor       <= '0;
                    end else begin
                        r_row_count <= RW'(rc1);
                    end
                    r_state <= emit ? S_DIV : S_IDLE;
                end

                S_DIV: begin
                    r_quo   <= step;
                    r_frac  <= step >> 1;          // half-step start
                    r_group <= '0;
                    r_cnt   <= '0;
                    r_state <= S_FETCH;
                end

                S_FETCH: begin
                    if (r_cnt < FETCH_ISSUE) begin
                        r_frac <= r_frac + r_quo;
                    end
                    if (r_cnt >= PIPE_LAT) begin
                        r_pix[3'(r_cnt - PIPE_LAT)] <= r_pal_q;
                    end
                    if (r_cnt == FETCH_LAST) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end

                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_cnt       <= '0;
                        if (r_group == GW'(GROUPS - 1)) begin
                            if (r_two) begin
                                // guard row: same source line, next row number
                                r_two   <= 1'b0;
                                r_orow  <= r_orow + NOW'(1);
                                r_group <= '0;
                                r_frac  <= r_quo >> 1;
                                r_state <= S_FETCH;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_group <= r_group + GW'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pix0        = {1'b1, r_pix[0]};
    assign o_pix1        = {1'b1, r_pix[1]};
    assign o_pix2        = {1'b1, r_pix[2]};
    assign o_pix3        = {1'b1, r_pix[3]};
    assign o_pix4        = {1'b1, r_pix[4]};
    assign o_pix5        = {1'b1, r_pix[5]};
    assign o_pix6        = {1'b1, r_pix[6]};
    assign o_pix7        = {1'b1, r_pix[7]};
    assign o_out_row     = pfs_pkg::ROW_PORT_W'(r_orow);
    assign o_group       = pfs_pkg::GROUP_PORT_W'(r_group);
    assign o_last_of_run = (r_group == GW'(GROUPS - 1)) && !r_two;

endmodule

// File: hdl/pfs_checker.sv
// Port-level checker for the palette frame scaler, bound to the top level.
// Depends on pfs_pkg and palette_frame_scaler_rgb5551_top_defines.svh.
`include "palette_frame_scaler_rgb5551_top_defines.svh"

module pfs_checker #(
    parameter int OUT_DIM = 256
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix0,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix1,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix2,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix3,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix4,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix5,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix6,
    input logic [pfs_pkg::PIX_W-1:0]        o_pix7,
    input logic [pfs_pkg::ROW_PORT_W-1:0]   o_out_row,
    input logic [pfs_pkg::GROUP_PORT_W-1:0] o_group,
    input logic                             o_last_of_run
);

    localparam int GROUPS = OUT_DIM / pfs_pkg::GROUP_PIX;

    // stalled group holds
    `PFS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pix0) && $stable(o_pix1) && $stable(o_pix2) && $stable(o_pix3) && $stable(o_pix4) && $stable(o_pix5) && $stable(o_pix6) && $stable(o_pix7) && $stable(o_out_row) && $stable(o_group) && $stable(o_last_of_run), "output transaction changed while stalled")

    // one item at a time: no input taken while a group waits
    `PFS_ASSERT_IMPL(a_no_overlap, o_out_valid, !o_in_ready, "input ready while output pending")

    // a run only ends on the last group of a row
    `PFS_ASSERT_IMPL(a_last_group, o_out_valid && o_last_of_run, o_group == pfs_pkg::GROUP_PORT_W'(GROUPS - 1), "last_of_run on inner group")

    `PFS_ASSERT_IMPL(a_row_range, o_out_valid, 32'(o_out_row) < 32'(OUT_DIM), "output row out of range")

    `PFS_ASSERT_RESET(a_reset_idle, !o_out_valid, "output valid after reset")

endmodule

bind palette_frame_scaler_rgb5551_top pfs_checker #(
    .OUT_DIM (OUT_DIM)
) u_pfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pix0        (o_pix0),
    .o_pix1        (o_pix1),
    .o_pix2        (o_pix2),
    .o_pix3        (o_pix3),
    .o_pix4        (o_pix4),
    .o_pix5        (o_pix5),
    .o_pix6        (o_pix6),
    .o_pix7        (o_pix7),
    .o_out_row     (o_out_row),
    .o_group       (o_group),
    .o_last_of_run (o_last_of_run)
);

// File: bench/pfs_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the palette frame scaler: predicts every output group from
// the observed config and input transactions and compares the output channel.
// Depends on pfs_pkg.
module pfs_frame_checker
    import pfs_pkg::*;
#(
    parameter int OUT_DIM         = 256,
    parameter int MAX_SOURCE_COLS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_kind,
    input  logic [INDEX_W-1:0]      i_pal_index,
    input  logic [CHAN_W-1:0]       i_red,
    input  logic [CHAN_W-1:0]       i_green,
    input  logic [CHAN_W-1:0]       i_blue,
    input  logic [INDEX_W-1:0]      i_pixel_index,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [PIX_W-1:0]        i_pix0,
    input  logic [PIX_W-1:0]        i_pix1,
    input  logic [PIX_W-1:0]        i_pix2,
    input  logic [PIX_W-1:0]        i_pix3,
    input  logic [PIX_W-1:0]        i_pix4,
    input  logic [PIX_W-1:0]        i_pix5,
    input  logic [PIX_W-1:0]        i_pix6,
    input  logic [PIX_W-1:0]        i_pix7,
    input  logic [ROW_PORT_W-1:0]   i_out_row,
    input  logic [GROUP_PORT_W-1:0] i_group,
    input  logic                    i_last_of_run,
    output int                      o_pending,
    output int                      o_mismatches
);

    localparam int GROUPS = OUT_DIM / GROUP_PIX;

    typedef struct packed {
        logic [GROUP_PIX-1:0][PIX_W-1:0] pix;
        logic [ROW_PORT_W-1:0]           row;
        logic [GROUP_PORT_W-1:0]         grp;
        logic                            last;
    } t_group;

    t_color                  palette  [256];
    logic [INDEX_W-1:0]      line_buf [MAX_SOURCE_COLS];
    logic [9:0]              col_cnt;
    logic [11:0]             row_cnt;
    logic [8:0]              next_row;
    logic [SRC_COLS_W-1:0]   cols_reg;
    logic [SRC_ROWS_W-1:0]   rows_reg;
    t_group                  groups_due [$];
    int                      errors = 0;

    logic [GROUP_PIX-1:0][PIX_W-1:0] seen_pix;

    assign seen_pix     = {i_pix7, i_pix6, i_pix5, i_pix4, i_pix3, i_pix2, i_pix1, i_pix0};
    assign o_mismatches = errors;

    function automatic int unsigned cols_eff();
        int unsigned c;
        c = cols_reg;
        if (c == 0) c = 1;
        if (c > MAX_SOURCE_COLS) c = MAX_SOURCE_COLS;
        return c;
    endfunction

    function automatic int unsigned rows_eff();
        return (rows_reg == 0) ? 1 : rows_reg;
    endfunction

    // Nearest-neighbor resample of the line buffer into one full output row.
    function automatic void expand_row(input int unsigned orow);
        int unsigned stride, pos, gi, k;
        t_group      g;
        stride = (cols_eff() << FRAC_BITS) / OUT_DIM;
        pos    = stride >> 1;
        for (gi = 0; gi < GROUPS; gi++) begin
            for (k = 0; k < GROUP_PIX; k++) begin
                g.pix[k] = {1'b1, palette[line_buf[(pos >> FRAC_BITS) % MAX_SOURCE_COLS]]};
                pos += stride;
            end
            g.row  = ROW_PORT_W'(orow);
            g.grp  = GROUP_PORT_W'(gi);
            g.last = 1'b0;
            groups_due.push_back(g);
        end
    endfunction

    function automatic void absorb_pixel(input logic [INDEX_W-1:0] idx);
        int unsigned cols, rows, start;
        t_group      tail;
        cols  = cols_eff();
        rows  = rows_eff();
        start = groups_due.size();
        line_buf[col_cnt] = idx;
        if (col_cnt + 1 < cols) begin
            col_cnt = col_cnt + 1;
            return;
        end
        col_cnt = '0;
        if (rows <= OUT_DIM) begin
            // short source: 1:1 rows, guard row after the last one
            if (row_cnt < OUT_DIM) begin
                expand_row(row_cnt);
                next_row = 9'(row_cnt + 1);
                if (rows < OUT_DIM && row_cnt + 1 >= rows && row_cnt + 1 < OUT_DIM)
                    expand_row(row_cnt + 1);
            end
        end else if (next_row < OUT_DIM) begin
            // tall source: keep only the selected source rows
            if ((next_row * rows) / OUT_DIM == row_cnt) begin
                expand_row(next_row);
                next_row = next_row + 1;
            end
        end
        if (row_cnt + 1 >= rows) begin
            row_cnt  = '0;
            col_cnt  = '0;
            next_row = '0;
        end else begin
            row_cnt = row_cnt + 1;
        end
        if (groups_due.size() > start) begin
            tail      = groups_due.pop_back();
            tail.last = 1'b1;
            groups_due.push_back(tail);
        end
    endfunction

    function automatic void check_group();
        t_group want;
        int     k;
        if (groups_due.size() == 0) begin
            $error("output group with nothing expected: out_row %0d, group %0d",
                   i_out_row, i_group);
            errors++;
            return;
        end
        want = groups_due.pop_front();
        for (k = 0; k < GROUP_PIX; k++) begin
            if (seen_pix[k] !== want.pix[k]) begin
                $error("pix%0d: expected %h, actual %h", k, want.pix[k], seen_pix[k]);
                errors++;
            end
        end
        if (i_out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, i_out_row);
            errors++;
        end
        if (i_group !== want.grp) begin
            $error("group: expected %0d, actual %0d", want.grp, i_group);
            errors++;
        end
        if (i_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, i_last_of_run);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cols_reg = SOURCE_COLS_RST;
            rows_reg = SOURCE_ROWS_RST;
            col_cnt  = '0;
            row_cnt  = '0;
            next_row = '0;
            groups_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SOURCE_COLS)
                    cols_reg = i_cfg_data[SRC_COLS_W-1:0];
                else if (i_cfg_index == REG_SOURCE_ROWS)
                    rows_reg = i_cfg_data[SRC_ROWS_W-1:0];
            end
            if (i_in_valid && i_in_ready) begin
                if (i_kind == KIND_PALETTE)
                    palette[i_pal_index] = {i_blue[7:3], i_green[7:3], i_red[7:3]};
                else
                    absorb_pixel(i_pixel_index);
            end
            if (i_out_valid && i_out_ready)
                check_group();
        end
        o_pending <= groups_due.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the palette frame scaler top level.
// Depends on pfs_pkg, palette_frame_scaler_rgb5551_top and pfs_frame_checker.
module tb_top;
    import pfs_pkg::*;

    // One emitted row: row select, step, 32 groups.
    localparam int ROW_CYCLES    = 2 + 1 + 32 * 11;
    // Settle time before a register write or the verdict: a row plus its guard.
    localparam int SETTLE_CYCLES = 2 * ROW_CYCLES + 64;
    localparam int RANDOM_ITEMS  = 35;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   cfg_data    = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic                    kind        = KIND_PALETTE;
    logic [INDEX_W-1:0]      pal_index   = '0;
    logic [CHAN_W-1:0]       red         = '0;
    logic [CHAN_W-1:0]       green       = '0;
    logic [CHAN_W-1:0]       blue        = '0;
    logic [INDEX_W-1:0]      pixel_index = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [PIX_W-1:0]        pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7;
    logic [ROW_PORT_W-1:0]   out_row;
    logic [GROUP_PORT_W-1:0] out_group;
    logic                    last_of_run;

    int groups_pending;
    int mismatches;

    // Idle knobs, changed per phase; both off for the closing phase.
    bit send_gaps   = 1'b0;
    bit recv_stalls = 1'b0;

    // Palette entries already loaded; pixels only ever reference these.
    logic [INDEX_W-1:0] known_colors [$];
    bit                 loaded [256];
    int                 items_sent = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    palette_frame_scaler_rgb5551_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (kind),
        .i_pal_index   (pal_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_pixel_index (pixel_index),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_pix0        (pix0),
        .o_pix1        (pix1),
        .o_pix2        (pix2),
        .o_pix3        (pix3),
        .o_pix4        (pix4),
        .o_pix5        (pix5),
        .o_pix6        (pix6),
        .o_pix7        (pix7),
        .o_out_row     (out_row),
        .o_group       (out_group),
        .o_last_of_run (last_of_run)
    );

    pfs_frame_checker i_frame_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (kind),
        .i_pal_index   (pal_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_pixel_index (pixel_index),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_pix0        (pix0),
        .i_pix1        (pix1),
        .i_pix2        (pix2),
        .i_pix3        (pix3),
        .i_pix4        (pix4),
        .i_pix5        (pix5),
        .i_pix6        (pix6),
        .i_pix7        (pix7),
        .i_out_row     (out_row),
        .i_group       (out_group),
        .i_last_of_run (last_of_run),
        .o_pending     (groups_pending),
        .o_mismatches  (mismatches)
    );

    // Output side: ready is high except for random stall bursts, which can
    // land on any group of a row, including the last one of a run.
    initial begin : output_side
        forever begin
            @(posedge clk);
            if (recv_stalls && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Called right after a rising edge; returns at the edge where the
    // transaction is taken. Valid stays up between back-to-back transactions.
    task automatic send_item(input logic k, input logic [7:0] pidx, r, g, b, px);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        pal_index   <= pidx;
        red         <= r;
        green       <= g;
        blue        <= b;
        pixel_index <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Palette load; the unused pixel field carries noise.
    task automatic put_color(input logic [7:0] idx, r, g, b);
        send_item(KIND_PALETTE, idx, r, g, b, 8'($urandom));
        if (!loaded[idx]) begin
            loaded[idx] = 1'b1;
            known_colors.push_back(idx);
        end
    endtask

    task automatic put_pixel(input logic [7:0] idx);
        send_item(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), idx);
    endtask

    function automatic logic [7:0] any_known();
        return known_colors[$urandom_range(0, known_colors.size() - 1)];
    endfunction

    // Raster pixels from loaded entries, with a palette load now and then
    // so new colors land in the middle of rows and frames.
    task automatic put_pixels(input int unsigned n);
        int unsigned j;
        for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0)
                put_color(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            put_pixel(any_known());
        end
    endtask

    // Hold the sender until every expected group is out, then give a
    // row-closing pixel that produced nothing time to finish.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (groups_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers, back to back, only with the block idle.
    task automatic configure(input int unsigned cols, rows);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SOURCE_COLS;
        cfg_data  <= CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_index <= REG_SOURCE_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly whole frames with random content; some partial frames, tall
    // sources and rows broken off in the middle.
    task automatic random_phase();
        int unsigned shape, cols, rows, n_rows, extra;
        shape       = $urandom_range(0, 9);
        send_gaps   = $urandom_range(0, 3) != 0;
        recv_stalls = $urandom_range(0, 3) != 0;
        extra       = 0;
        case (shape)
            0, 1, 2, 3, 4: begin
                cols   = $urandom_range(1, 6);
                rows   = $urandom_range(1, 6);
                n_rows = rows;
            end
            5: begin
                cols   = $urandom_range(7, 48);
                rows   = $urandom_range(1, 3);
                n_rows = rows;
            end
            6: begin
                cols   = $urandom_range(1, 4);
                rows   = $urandom_range(2, 6);
                n_rows = 2 * rows;
            end
            7: begin
                cols   = $urandom_range(1, 3);
                rows   = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(257, 4095);
                n_rows = $urandom_range(1, 40);
            end
            8: begin
                cols   = $urandom_range(1, 6);
                rows   = $urandom_range(1, 256);
                n_rows = $urandom_range(1, 8);
            end
            default: begin
                cols   = $urandom_range(0, 6);
                rows   = $urandom_range(0, 6);
                n_rows = $urandom_range(0, 3);
                extra  = $urandom_range(1, 5);
            end
        endcase
        configure(cols, rows);
        put_pixels(n_rows * ((cols == 0) ? 1 : cols) + extra);
    endtask

    initial begin : stimulus
        int start;
        int j;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme colors; the low three bits of each channel must drop.
        put_color(8'h00, 8'h00, 8'h00, 8'h00);
        put_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        put_color(8'hAA, 8'h07, 8'hF8, 8'h80);
        put_color(8'h55, 8'hF8, 8'h07, 8'h7F);

        // Reset geometry, 320 x 240: one full row gives output row 0.
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        for (j = 0; j < 320; j++)
            put_pixel(any_known());

        // Height 1 with the row counter already past it: row 1 plus guard.
        configure(1, 1);
        put_pixel(8'hFF);

        // Small frame: recolor between rows, guard row after the last row.
        configure(4, 3);
        put_pixel(8'h00);
        put_pixel(8'hFF);
        put_pixel(8'hAA);
        put_pixel(8'h55);
        put_color(8'h00, 8'h80, 8'h40, 8'h20);
        put_pixel(8'h55);
        put_pixel(8'hAA);
        put_pixel(8'hFF);
        put_pixel(8'h00);
        put_pixel(8'h00);
        put_pixel(8'h00);
        put_pixel(8'hFF);
        put_pixel(8'hFF);

        // Zero width and height behave as 1 x 1: each pixel is a frame.
        configure(0, 0);
        put_pixel(8'hFF);
        put_pixel(8'hAA);

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
            random_phase();

        // Closing phase runs with no idling on either side.
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        configure(3, 2);
        put_pixels(12);
        configure(5, 4);
        put_pixels(20);

        drain();
        if (mismatches == 0 && groups_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin : watchdog
        #(50_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
